// ===== rtl/core/rat_pkg.sv =====
// ----------------------------------------------------------------------------
// Repeating alarm table package
// Shared types, command and event codes and constants of the alarm table.
// ----------------------------------------------------------------------------
package rat_pkg;

   localparam int TableDepth = 16;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);
   localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;
   localparam logic [31:0] LookaheadReset = 32'd86400;
   localparam logic [10:0] DefaultExpiryReset = 11'd15;
   localparam logic [5:0] SecondsPerMinute = 6'd60;

   localparam logic [0:0] CSR_LOOKAHEAD = 1'd0;
   localparam logic [0:0] CSR_DEFAULT_EXPIRY = 1'd1;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_TICK = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      EV_STATUS = 3'd0,
      EV_SIGNAL = 3'd1,
      EV_REPEAT = 3'd2,
      EV_REACTION = 3'd3,
      EV_DECLINED = 3'd4,
      EV_ADDED = 3'd5,
      EV_DROPPED = 3'd6,
      EV_REMOVE_NONE = 3'd7
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPIRE,
      ST_ACTIVATE,
      ST_FIND,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [31:0] now_secs;
      logic [31:0] trigger_secs;
      logic [10:0] expiry_minutes;
      logic [7:0] repeat_count;
      logic [7:0] alarm_name_id;
      logic accepted;
   } req_type;

   typedef struct packed {
      logic [2:0] event_kind;
      logic [7:0] event_name_id;
      logic any_due;
      logic next_found;
      logic [31:0] next_event_time;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] trigger;
      logic [31:0] expiry;
      logic [15:0] period;
      logic [7:0] repeats;
      logic active;
      logic rearmed;
      logic [7:0] name;
   } entry_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? TimeMax : s[31:0];
   endfunction

endpackage

// ===== rtl/core/repeating_alarm_table.sv =====
// ----------------------------------------------------------------------------
// Repeating alarm table
// Ordered, gap-free table of repeating alarms with add, tick and remove.
// ----------------------------------------------------------------------------
// Channel  Ports              Handshake
// request  req_*, start/busy  taken when start is high and busy low
// result   rsp_*              rsp_valid strobe per result; last marks the final
// config   csr_*              written when csr_write is high
//
// Add gives its result in the cycle after acceptance and never raises busy.
// Tick holds busy for two passes over the table: one for expiry with
// compaction, one for activation and the window search (the entry
// memory has one registered read and one write per cycle). The status result
// follows as the last result of the tick.
// Remove holds busy for the search and close-up; its result comes with the
// match, or after the search when no active entry matches.
// Reset is synchronous; the table comes up empty. The receiver cannot stall.
module repeating_alarm_table (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  rat_pkg::req_type req_data,
   output logic rsp_valid,
   output rat_pkg::rsp_type rsp_data,
   input  logic csr_write,
   input  logic [0:0] csr_index,
   input  logic [31:0] csr_wdata
);
   import rat_pkg::*;

   entry_type mem [TableDepth];

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic [CntW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] wr_ff, wr_in;
   logic any_due_ff, any_due_in;
   logic found_ff, found_in;
   logic [31:0] best_ff, best_in;
   logic [31:0] look_ff;
   logic [10:0] defexp_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   entry_type cur_ff;

   logic we;
   logic [IdxW-1:0] waddr;
   entry_type wdata;
   entry_type cur;
   logic [31:0] t_ev;
   logic [10:0] mins;
   logic [16:0] per_full;
   logic [15:0] per;

   assign cur = cur_ff;
   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         look_ff <= LookaheadReset;
         defexp_ff <= DefaultExpiryReset;
      end else if (csr_write) begin
         if (csr_index == CSR_LOOKAHEAD) look_ff <= csr_wdata;
         if (csr_index == CSR_DEFAULT_EXPIRY) defexp_ff <= csr_wdata[10:0];
      end
   end

   // The read address is the next entry, so its data is ready when it is used.
   // Writes in a tick or remove pass land below it, so reads never see stale data.
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      cur_ff <= mem[rd_in[IdxW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rd_ff <= rd_in;
      wr_ff <= wr_in;
      any_due_ff <= any_due_in;
      found_ff <= found_in;
      best_ff <= best_in;
      rsp_ff <= rsp_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.cmd)
                  CMD_TICK: state_in = ST_EXPIRE;
                  CMD_REMOVE: state_in = ST_FIND;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EXPIRE: if (rd_ff >= fill_ff) state_in = ST_ACTIVATE;
         ST_ACTIVATE: if (rd_ff >= fill_ff) state_in = ST_IDLE;
         ST_FIND: begin
            if (rd_ff >= fill_ff) state_in = ST_IDLE;
            else if (cur.active && cur.name == req_ff.alarm_name_id) state_in = ST_SHIFT;
         end
         ST_SHIFT: if (rd_ff >= fill_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mins = (req_data.expiry_minutes == 11'd0) ? defexp_ff : req_data.expiry_minutes;
      per_full = {6'd0, mins} * {11'd0, SecondsPerMinute};
      per = (per_full > 17'h0FFFF) ? 16'hFFFF : per_full[15:0];
      // Event time of the entry as it stands after activation.
      t_ev = ((cur.active || req_ff.now_secs >= cur.trigger) && cur.repeats != 8'd0)
             ? cur.expiry : cur.trigger;
   end

   // Outputs and datapath.
   always_comb begin
      req_in = req_ff;
      fill_in = fill_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      any_due_in = any_due_ff;
      found_in = found_ff;
      best_in = best_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '0;
      we = 1'b0;
      waddr = wr_ff[IdxW-1:0];
      wdata = cur;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               rd_in = '0;
               wr_in = '0;
               any_due_in = 1'b0;
               found_in = 1'b0;
               best_in = sat_add(req_data.now_secs, look_ff);
               if (req_data.cmd == CMD_ADD) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.event_name_id = req_data.alarm_name_id;
                  rsp_in.last = 1'b1;
                  if (fill_ff >= CntW'(TableDepth)) begin
                     rsp_in.event_kind = EV_DROPPED;
                  end else begin
                     rsp_in.event_kind = EV_ADDED;
                     we = 1'b1;
                     waddr = fill_ff[IdxW-1:0];
                     wdata.trigger = req_data.trigger_secs;
                     wdata.period = per;
                     wdata.expiry = sat_add(req_data.trigger_secs, {16'd0, per});
                     wdata.repeats = req_data.repeat_count;
                     wdata.active = 1'b0;
                     wdata.rearmed = 1'b0;
                     wdata.name = req_data.alarm_name_id;
                     fill_in = fill_ff + 1'b1;
                  end
               end
            end
         end
         ST_EXPIRE: begin
            if (rd_ff >= fill_ff) begin
               fill_in = wr_ff;
               rd_in = '0;
            end else begin
               rd_in = rd_ff + 1'b1;
               if (req_ff.now_secs >= cur.expiry) begin
                  if (cur.repeats != 8'd0) begin
                     wdata.trigger = sat_add(cur.trigger, {16'd0, cur.period});
                     wdata.expiry = sat_add(wdata.trigger, {16'd0, cur.period});
                     wdata.repeats = cur.repeats - 8'd1;
                     wdata.rearmed = 1'b1;
                     wdata.active = 1'b0;
                     we = 1'b1;
                     wr_in = wr_ff + 1'b1;
                  end
               end else begin
                  we = 1'b1;
                  wr_in = wr_ff + 1'b1;
               end
            end
         end
         ST_ACTIVATE: begin
            // Activation and window search share the same pass.
            if (rd_ff >= fill_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in.event_kind = EV_STATUS;
               rsp_in.any_due = any_due_ff;
               rsp_in.next_found = found_ff;
               rsp_in.next_event_time = best_ff;
               rsp_in.last = 1'b1;
            end else begin
               rd_in = rd_ff + 1'b1;
               waddr = rd_ff[IdxW-1:0];
               if (req_ff.now_secs >= cur.trigger) begin
                  any_due_in = 1'b1;
                  if (!cur.active) begin
                     wdata.active = 1'b1;
                     we = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_in.event_kind = cur.rearmed ? EV_REPEAT : EV_SIGNAL;
                     rsp_in.event_name_id = cur.name;
                  end
               end
               if (t_ev > req_ff.now_secs && t_ev < best_ff) begin
                  best_in = t_ev;
                  found_in = 1'b1;
               end
            end
         end
         ST_FIND: begin
            if (rd_ff >= fill_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in.event_kind = EV_REMOVE_NONE;
               rsp_in.event_name_id = req_ff.alarm_name_id;
               rsp_in.last = 1'b1;
            end else if (cur.active && cur.name == req_ff.alarm_name_id) begin
               rsp_valid_in = 1'b1;
               rsp_in.event_kind = req_ff.accepted ? EV_REACTION : EV_DECLINED;
               rsp_in.event_name_id = cur.name;
               rsp_in.last = 1'b1;
               wr_in = rd_ff;
               rd_in = rd_ff + 1'b1;
            end else begin
               rd_in = rd_ff + 1'b1;
            end
         end
         ST_SHIFT: begin
            if (rd_ff >= fill_ff) begin
               fill_in = fill_ff - 1'b1;
            end else begin
               we = 1'b1;
               wr_in = wr_ff + 1'b1;
               rd_in = rd_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) fill_ff <= CntW'(TableDepth))
      else $error("fill count beyond table depth");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |=> !rsp_valid_ff || !$past(busy) || !busy)
      else $error("result after final result");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXPIRE) |-> wr_ff <= rd_ff)
      else $error("compaction write passed read");
endmodule
